@@ src/ip_address_port_text_parser_macros.svh @@
// Assertion macros for the address text parser.
// Included by the top level; expects clk and rst_n in scope.
`ifndef IP_ADDRESS_PORT_TEXT_PARSER_MACROS_SVH
`define IP_ADDRESS_PORT_TEXT_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define IPAPT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define IPAPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ipapt_pkg.sv @@
// Shared types, character codes and helpers for the address text parser.
// No dependencies; used by ipapt_parser and ip_address_port_text_parser.
`timescale 1ns / 1ps

package ipapt_pkg;

  // Character codes that steer the parse.
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // Field limits.
  localparam logic [16:0] OCTET_MAX  = 17'd255;
  localparam logic [16:0] PORT_MAX   = 17'd65535;
  localparam logic [2:0]  OCTET_DIGS = 3'd3;
  localparam logic [2:0]  PORT_DIGS  = 3'd5;
  localparam logic [2:0]  GROUP_DIGS = 3'd4;
  localparam logic [3:0]  NUM_GROUPS = 4'd8;

  // One parse result, as it leaves the parser.
  typedef struct packed {
    logic        valid_res;
    logic        is_v6;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [15:0] port_number;
  } res_t;

  // Hex digit decode: bit 4 flags a hex digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

endpackage

@@ src/ipapt_parser.sv @@
// Character-at-a-time parse state for the address text parser.
// Depends on ipapt_pkg; gives the result for the current character combinationally.
`timescale 1ns / 1ps

module ipapt_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  logic [7:0]       char_code,
  input  logic             last_char,
  output ipapt_pkg::res_t  res
);

  typedef enum logic [3:0] {
    PH_START,
    PH_V4,
    PH_V6_BEGIN,
    PH_V6_LEAD,
    PH_V6_GAP,
    PH_V6_GROUP,
    PH_V6_COLON,
    PH_V6_CLOSE,
    PH_PORT
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic        err_r, err_nxt;
  logic [16:0] dv_r, dv_nxt;
  logic [2:0]  dc_r, dc_nxt;
  logic        fz_r, fz_nxt;
  logic [3:0]  nb_r, nb_nxt;
  logic [3:0]  na_r, na_nxt;
  logic        gap_r, gap_nxt;
  logic [1:0]  oi_r, oi_nxt;
  logic [31:0] oct_r, oct_nxt;

  // Group stores: groups before the gap sit at their own index, groups after
  // the gap shift in from the top so the last one always lands in slot 7.
  logic [15:0] before_r [8];
  logic [15:0] after_r  [8];
  logic        wr_before, wr_after;

  // Character decode.
  logic        is_dig;
  logic [4:0]  hex_dec;
  logic        is_hex;
  logic [2:0]  dc_inc;
  logic [19:0] dec_wide;
  logic [16:0] dec_val;
  logic [16:0] hex_val;
  logic        dok_octet;
  logic [3:0]  total;

  assign is_dig    = (char_code >= ipapt_pkg::CH_ZERO) && (char_code <= ipapt_pkg::CH_NINE);
  assign hex_dec   = ipapt_pkg::hex_digit(char_code);
  assign is_hex    = hex_dec[4];
  assign dc_inc    = dc_r + 3'd1;
  assign dec_wide  = ({3'b0, dv_r} << 3) + ({3'b0, dv_r} << 1) + {16'd0, char_code[3:0]};
  assign dec_val   = dec_wide[16:0];
  assign hex_val   = {dv_r[12:0], hex_dec[3:0]};
  assign total     = nb_r + na_r;
  assign dok_octet = (dc_r != 3'd0) && !(fz_r && dc_r > 3'd1) && (dv_r <= ipapt_pkg::OCTET_MAX);

  // Next parse state for one character.
  always_comb begin
    logic       do_dec;
    logic [2:0] dec_lim;
    logic       do_hex;
    logic       do_push;
    logic       do_end;
    logic [3:0] total_n;
    phase_nxt = phase_r;
    err_nxt   = err_r;
    dv_nxt    = dv_r;
    dc_nxt    = dc_r;
    fz_nxt    = fz_r;
    nb_nxt    = nb_r;
    na_nxt    = na_r;
    gap_nxt   = gap_r;
    oi_nxt    = oi_r;
    oct_nxt   = oct_r;
    wr_before = 1'b0;
    wr_after  = 1'b0;
    do_dec    = 1'b0;
    dec_lim   = ipapt_pkg::OCTET_DIGS;
    do_hex    = 1'b0;
    do_push   = 1'b0;
    do_end    = 1'b0;
    total_n   = 4'd0;

    if (take && !err_r) begin
      unique case (phase_r)
        PH_START: begin
          if (char_code == ipapt_pkg::CH_LBRACK) begin
            phase_nxt = PH_V6_BEGIN;
          end else if (is_dig) begin
            phase_nxt = PH_V4;
            do_dec    = 1'b1;
          end else begin
            err_nxt = 1'b1;
          end
        end
        PH_V4: begin
          if (is_dig) begin
            do_dec = 1'b1;
          end else if ((char_code == ipapt_pkg::CH_DOT && oi_r != 2'd3) ||
                       (char_code == ipapt_pkg::CH_COLON && oi_r == 2'd3)) begin
            if (!dok_octet) begin
              err_nxt = 1'b1;
            end else begin
              oct_nxt = {oct_r[23:0], dv_r[7:0]};
              dv_nxt  = 17'd0;
              dc_nxt  = 3'd0;
              fz_nxt  = 1'b0;
              if (char_code == ipapt_pkg::CH_DOT) begin
                oi_nxt = oi_r + 2'd1;
              end else begin
                phase_nxt = PH_PORT;
              end
            end
          end else begin
            err_nxt = 1'b1;
          end
        end
        PH_V6_BEGIN: begin
          if (char_code == ipapt_pkg::CH_COLON) begin
            phase_nxt = PH_V6_LEAD;
          end else if (is_hex) begin
            phase_nxt = PH_V6_GROUP;
            do_hex    = 1'b1;
          end else begin
            err_nxt = 1'b1;
          end
        end
        PH_V6_LEAD: begin
          if (char_code == ipapt_pkg::CH_COLON) begin
            gap_nxt   = 1'b1;
            phase_nxt = PH_V6_GAP;
          end else begin
            err_nxt = 1'b1;
          end
        end
        PH_V6_GAP, PH_V6_COLON: begin
          if (is_hex) begin
            phase_nxt = PH_V6_GROUP;
            do_hex    = 1'b1;
          end else if (char_code == ipapt_pkg::CH_RBRACK && phase_r == PH_V6_GAP) begin
            do_end = 1'b1;
          end else if (char_code == ipapt_pkg::CH_COLON && phase_r == PH_V6_COLON &&
                       !gap_r) begin
            gap_nxt   = 1'b1;
            phase_nxt = PH_V6_GAP;
          end else begin
            err_nxt = 1'b1;
          end
        end
        PH_V6_GROUP: begin
          if (is_hex) begin
            do_hex = 1'b1;
          end else if (char_code == ipapt_pkg::CH_COLON) begin
            do_push   = 1'b1;
            phase_nxt = PH_V6_COLON;
          end else if (char_code == ipapt_pkg::CH_RBRACK) begin
            do_push = 1'b1;
            do_end  = 1'b1;
          end else begin
            err_nxt = 1'b1;
          end
        end
        PH_V6_CLOSE: begin
          if (char_code == ipapt_pkg::CH_COLON) begin
            phase_nxt = PH_PORT;
          end else begin
            err_nxt = 1'b1;
          end
        end
        PH_PORT: begin
          if (is_dig) begin
            do_dec  = 1'b1;
            dec_lim = ipapt_pkg::PORT_DIGS;
          end else begin
            err_nxt = 1'b1;
          end
        end
        default: begin
          err_nxt = 1'b1;
        end
      endcase
    end

    // Decimal digit into an octet or the port.
    if (do_dec) begin
      if (dc_r == 3'd0) begin
        fz_nxt = (char_code == ipapt_pkg::CH_ZERO);
      end
      dc_nxt = dc_inc;
      if (dc_inc > dec_lim) begin
        err_nxt = 1'b1;
      end else begin
        dv_nxt = dec_val;
      end
    end

    // Hex digit into an IPv6 group.
    if (do_hex) begin
      dc_nxt = dc_inc;
      if (dc_inc > ipapt_pkg::GROUP_DIGS) begin
        err_nxt = 1'b1;
      end else begin
        dv_nxt = hex_val;
      end
    end

    // Close a group; a ninth group fails at once.
    if (do_push) begin
      if (total >= ipapt_pkg::NUM_GROUPS) begin
        err_nxt = 1'b1;
      end else begin
        if (gap_r) begin
          wr_after = 1'b1;
          na_nxt   = na_r + 4'd1;
        end else begin
          wr_before = 1'b1;
          nb_nxt    = nb_r + 4'd1;
        end
        dv_nxt = 17'd0;
        dc_nxt = 3'd0;
        fz_nxt = 1'b0;
      end
    end

    // Closing bracket: the group count must fit the gap rule.
    if (do_end && !err_nxt) begin
      total_n = nb_nxt + na_nxt;
      if (gap_nxt ? (total_n > 4'd7) : (total_n != ipapt_pkg::NUM_GROUPS)) begin
        err_nxt = 1'b1;
      end else begin
        phase_nxt = PH_V6_CLOSE;
      end
    end
  end

  // Result for the current character, taken by the caller on the last one.
  always_comb begin
    logic [15:0] g;
    logic [4:0]  hi_idx;
    res = '0;
    g   = 16'd0;
    hi_idx = 5'd0;
    if (!err_nxt && phase_nxt == PH_PORT && dc_nxt != 3'd0 &&
        !(fz_nxt && dc_nxt > 3'd1) && dv_nxt <= ipapt_pkg::PORT_MAX) begin
      res.valid_res   = 1'b1;
      res.port_number = dv_nxt[15:0];
      if (oi_nxt == 2'd3) begin
        res.addr_low = {32'd0, oct_nxt};
      end else begin
        res.is_v6 = 1'b1;
        for (int i = 0; i < 8; i++) begin
          hi_idx = 5'(i) + {1'b0, na_r};
          if (4'(i) < nb_r) begin
            g = before_r[i];
          end else if (hi_idx >= 5'd8) begin
            g = after_r[i];
          end else begin
            g = 16'd0;
          end
          if (i < 4) begin
            res.addr_high[63 - 16*i -: 16] = g;
          end else begin
            res.addr_low[63 - 16*(i-4) -: 16] = g;
          end
        end
      end
    end
  end

  // Control state; cleared by reset and after the last character.
  always_ff @(posedge clk) begin
    if (!rst_n || (take && last_char)) begin
      phase_r <= PH_START;
      err_r   <= 1'b0;
      dv_r    <= 17'd0;
      dc_r    <= 3'd0;
      fz_r    <= 1'b0;
      nb_r    <= 4'd0;
      na_r    <= 4'd0;
      gap_r   <= 1'b0;
      oi_r    <= 2'd0;
      oct_r   <= 32'd0;
    end else begin
      phase_r <= phase_nxt;
      err_r   <= err_nxt;
      dv_r    <= dv_nxt;
      dc_r    <= dc_nxt;
      fz_r    <= fz_nxt;
      nb_r    <= nb_nxt;
      na_r    <= na_nxt;
      gap_r   <= gap_nxt;
      oi_r    <= oi_nxt;
      oct_r   <= oct_nxt;
    end
  end

  // Group stores hold payload only; they are read only where written.
  always_ff @(posedge clk) begin
    if (wr_before) begin
      before_r[nb_r[2:0]] <= dv_r[15:0];
    end
    if (wr_after) begin
      for (int j = 0; j < 7; j++) begin
        after_r[j] <= after_r[j+1];
      end
      after_r[7] <= dv_r[15:0];
    end
  end

endmodule

@@ src/ip_address_port_text_parser.sv @@
// Top level of the address text parser: handshakes, result register, checks.
// Depends on ipapt_pkg, ipapt_parser and ip_address_port_text_parser_macros.svh.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake             Payload
//  in_       input      in_valid / in_ready   in_char_code[7:0], in_last_char
//  out_      output     out_valid / out_ready out_valid_res, out_is_v6,
//                                             out_addr_high, out_addr_low,
//                                             out_port_number
//
// One character is taken per cycle while in_ready is high; the parse state updates at the same edge.
// A result appears in a register in the cycle after its last character is taken.
// in_ready falls only while a result waits and out_ready is low.
// Reset is synchronous and clears the parse state and out_valid at once.

`include "ip_address_port_text_parser_macros.svh"

module ip_address_port_text_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_code,
  input  logic        in_last_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_valid_res,
  output logic        out_is_v6,
  output logic [63:0] out_addr_high,
  output logic [63:0] out_addr_low,
  output logic [15:0] out_port_number
);

  logic            take;
  logic            out_valid_r;
  ipapt_pkg::res_t res;
  ipapt_pkg::res_t res_r;

  // A new transaction is taken unless a result is stuck in the output register.
  assign in_ready = !out_valid_r || out_ready;
  assign take     = in_valid && in_ready;

  ipapt_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .char_code (in_char_code),
    .last_char (in_last_char),
    .res       (res)
  );

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take && in_last_char) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload, loaded with the last character.
  always_ff @(posedge clk) begin
    if (take && in_last_char) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_valid_res   = res_r.valid_res;
  assign out_is_v6       = res_r.is_v6;
  assign out_addr_high   = res_r.addr_high;
  assign out_addr_low    = res_r.addr_low;
  assign out_port_number = res_r.port_number;

  // Checks.
  `IPAPT_ASSERT_NEXT(a_last_gives_result, take && in_last_char, out_valid_r, "last char gave no result")
  `IPAPT_ASSERT_NOW(a_stall_blocks_input, out_valid_r && !out_ready, !in_ready, "input taken while result stalled")
  `IPAPT_ASSERT_NOW(a_invalid_is_zero, out_valid_r && !res_r.valid_res, !res_r.is_v6 && res_r.port_number == 16'd0 && res_r.addr_high == 64'd0 && res_r.addr_low == 64'd0, "failed parse carries nonzero fields")
  `IPAPT_ASSERT_NOW(a_v4_upper_zero, out_valid_r && res_r.valid_res && !res_r.is_v6, res_r.addr_high == 64'd0 && res_r.addr_low[63:32] == 32'd0, "IPv4 result has upper bits set")

endmodule
